// ===== hdl/gni_pkg.sv =====
// Shared types and constants of the grid neighbour index generator.
`timescale 1ns / 1ps
package gni_pkg;

	localparam int IDX_W     = 24;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 4;
	localparam int NDIR      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

	localparam int DIR_LOWER       = 0;
	localparam int DIR_LEFT        = 1;
	localparam int DIR_RIGHT       = 2;
	localparam int DIR_UPPER       = 3;
	localparam int DIR_LOWER_LEFT  = 4;
	localparam int DIR_LOWER_RIGHT = 5;
	localparam int DIR_UPPER_LEFT  = 6;
	localparam int DIR_UPPER_RIGHT = 7;

	typedef struct packed {
		logic             valid;
		logic             diag;
		logic [IDX_W-1:0] index;
	} gni_ctl_t;

endpackage

// ===== hdl/gni_div_cell.sv =====
// One restoring-division cell: resolves a single quotient bit of index / width.
`timescale 1ns / 1ps
module gni_div_cell import gni_pkg::*; #(
	parameter int DIM_W = 13,
	parameter int BIT   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [DIM_W-1:0] width,
	input  gni_ctl_t         ctl_i,
	input  logic [IDX_W-1:0] rem_i,
	input  logic [DIM_W-1:0] quo_i,
	output gni_ctl_t         ctl_o,
	output logic [IDX_W-1:0] rem_o,
	output logic [DIM_W-1:0] quo_o
);

	localparam int CMP_W = IDX_W + DIM_W;

	logic [CMP_W-1:0] shifted;
	logic             ge;
	logic [IDX_W-1:0] rem_n;
	logic [DIM_W-1:0] quo_n;
	logic             valid_q;
	logic             diag_q;
	logic [IDX_W-1:0] index_q;
	logic [IDX_W-1:0] rem_q;
	logic [DIM_W-1:0] quo_q;

	always_comb begin
		shifted = CMP_W'(width) << BIT;
		ge      = CMP_W'(rem_i) >= shifted;
		rem_n   = ge ? (rem_i - shifted[IDX_W-1:0]) : rem_i;
		quo_n   = quo_i;
		quo_n[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diag_q  <= ctl_i.diag;
			index_q <= ctl_i.index;
			rem_q   <= rem_n;
			quo_q   <= quo_n;
		end
	end

	assign ctl_o = '{valid: valid_q, diag: diag_q, index: index_q};
	assign rem_o = rem_q;
	assign quo_o = quo_q;

endmodule

// ===== hdl/gni_emit.sv =====
// Neighbour serializer: in-bounds mask, one neighbour per cycle when not stalled.
`timescale 1ns / 1ps
module gni_emit import gni_pkg::*; #(
	parameter int DIM_W = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DIM_W-1:0]   width,
	input  logic [DIM_W-1:0]   height,
	input  logic [2*DIM_W-1:0] area,
	input  gni_ctl_t           ctl_i,
	input  logic [IDX_W-1:0]   rem_i,
	input  logic [DIM_W-1:0]   quo_i,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   out_index,
	output logic               out_found,
	output logic               out_error,
	output logic               out_last
);

	localparam int CMP_W = 2 * DIM_W + IDX_W;

	logic [DIM_W-1:0] row;
	logic [DIM_W-1:0] col;
	logic [DIM_W:0]   row_p1;
	logic [DIM_W:0]   col_p1;
	logic             has_lo;
	logic             has_hi;
	logic             has_l;
	logic             has_r;
	logic             err_n;
	logic [NDIR-1:0]  mask_n;

	logic             busy_q;
	logic             single_q;
	logic             err_q;
	logic [NDIR-1:0]  mask_q;
	logic [IDX_W-1:0] base_lo_q;
	logic [IDX_W-1:0] base_mid_q;
	logic [IDX_W-1:0] base_hi_q;

	logic [NDIR-1:0]  pick;
	logic [NDIR-1:0]  mask_rest;
	logic             step;
	logic             finishing;
	logic [IDX_W-1:0] base_sel;
	logic [IDX_W-1:0] nb_index;

	logic             o_valid_q;
	logic [IDX_W-1:0] o_index_q;
	logic             o_found_q;
	logic             o_error_q;
	logic             o_last_q;

	always_comb begin
		row    = quo_i;
		col    = rem_i[DIM_W-1:0];
		row_p1 = (DIM_W+1)'(row) + (DIM_W+1)'(1);
		col_p1 = (DIM_W+1)'(col) + (DIM_W+1)'(1);
		has_lo = row != '0;
		has_l  = col != '0;
		has_hi = row_p1 < (DIM_W+1)'(height);
		has_r  = col_p1 < (DIM_W+1)'(width);
		err_n  = CMP_W'(ctl_i.index) >= CMP_W'(area);
		mask_n = '0;
		mask_n[DIR_LOWER]       = has_lo;
		mask_n[DIR_LEFT]        = has_l;
		mask_n[DIR_RIGHT]       = has_r;
		mask_n[DIR_UPPER]       = has_hi;
		mask_n[DIR_LOWER_LEFT]  = ctl_i.diag & has_lo & has_l;
		mask_n[DIR_LOWER_RIGHT] = ctl_i.diag & has_lo & has_r;
		mask_n[DIR_UPPER_LEFT]  = ctl_i.diag & has_hi & has_l;
		mask_n[DIR_UPPER_RIGHT] = ctl_i.diag & has_hi & has_r;
	end

	always_comb begin
		pick = '0;
		for (int i = NDIR - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = '0;
				pick[i] = 1'b1;
			end
		end
		mask_rest = mask_q & ~pick;
		step      = busy_q && (!o_valid_q || out_ready);
		finishing = step && (single_q || mask_rest == '0);
		take      = ctl_i.valid && (!busy_q || finishing);
	end

	always_comb begin
		if (pick[DIR_LOWER] || pick[DIR_LOWER_LEFT] || pick[DIR_LOWER_RIGHT]) begin
			base_sel = base_lo_q;
		end else if (pick[DIR_UPPER] || pick[DIR_UPPER_LEFT] || pick[DIR_UPPER_RIGHT]) begin
			base_sel = base_hi_q;
		end else begin
			base_sel = base_mid_q;
		end
		if (pick[DIR_LEFT] || pick[DIR_LOWER_LEFT] || pick[DIR_UPPER_LEFT]) begin
			nb_index = base_sel - IDX_W'(1);
		end else if (pick[DIR_RIGHT] || pick[DIR_LOWER_RIGHT] || pick[DIR_UPPER_RIGHT]) begin
			nb_index = base_sel + IDX_W'(1);
		end else begin
			nb_index = base_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end else if (finishing) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			single_q   <= err_n || (mask_n == '0);
			err_q      <= err_n;
			mask_q     <= mask_n;
			base_mid_q <= ctl_i.index;
			base_lo_q  <= ctl_i.index - IDX_W'(width);
			base_hi_q  <= ctl_i.index + IDX_W'(width);
		end else if (step) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (!o_valid_q || out_ready) begin
			o_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (single_q) begin
				o_index_q <= '0;
				o_found_q <= 1'b0;
				o_error_q <= err_q;
				o_last_q  <= 1'b1;
			end else begin
				o_index_q <= nb_index;
				o_found_q <= 1'b1;
				o_error_q <= 1'b0;
				o_last_q  <= mask_rest == '0;
			end
		end
	end

	assign out_valid = o_valid_q;
	assign out_index = o_index_q;
	assign out_found = o_found_q;
	assign out_error = o_error_q;
	assign out_last  = o_last_q;

	a_miss_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && !o_found_q |-> o_last_q)
		else $error("result without neighbour not marked last");

	a_error_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && o_error_q |-> !o_found_q)
		else $error("error result carries a neighbour");

	a_step_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		step && !single_q |-> $onehot(pick))
		else $error("emission step with empty neighbour mask");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy_q)
		else $error("loaded request not held");

endmodule

// ===== hdl/grid_neighbour_index_generator.sv =====
// Grid neighbour index generator: divider cell chain, neighbour serializer, config registers.
// A request passes the divider cells, then the serializer state, then the output register.
// Throughput: one result per cycle while m_tready is high; a request yields one result per
//   neighbour found, or one result with found low if none or if its index is out of range.
// The divider chain takes a new request every cycle while the serializer keeps up.
// Reset: asynchronous, clears all valid flags; grid width and height return to 1.
`timescale 1ns / 1ps
module grid_neighbour_index_generator import gni_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IDX_W-1:0]     s_tdata,   // [23:0] cell_index
	input  logic                 s_tuser,   // [0] with_diagonals
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [IDX_W-1:0]     m_tdata,   // [23:0] neighbour_index
	output logic [1:0]           m_tuser,   // [0] found, [1] index_error
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DW_RAW = $clog2(MAX_DIM + 1);
	localparam int DIM_W  = (DW_RAW < CFG_W) ? DW_RAW : CFG_W;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [2*DIM_W-1:0] area_q;
	logic [31:0]        dim_wide;
	logic [DIM_W-1:0]   dim_n;
	logic               en;
	logic               take;

	gni_ctl_t         ctl_c [DIM_W+1];
	logic [IDX_W-1:0] rem_c [DIM_W+1];
	logic [DIM_W-1:0] quo_c [DIM_W+1];

	always_comb begin
		if (cfg_data == '0) begin
			dim_wide = 32'd1;
		end else if (32'(cfg_data) > 32'(MAX_DIM)) begin
			dim_wide = 32'(MAX_DIM);
		end else begin
			dim_wide = 32'(cfg_data);
		end
		dim_n = dim_wide[DIM_W-1:0];
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			area_q   <= (2*DIM_W)'(1);
		end else begin
			area_q <= (2*DIM_W)'(width_q) * (2*DIM_W)'(height_q);
			if (cfg_valid) begin
				case (cfg_index)
					REG_GRID_WIDTH:  width_q  <= dim_n;
					REG_GRID_HEIGHT: height_q <= dim_n;
					default: ;
				endcase
			end
		end
	end

	assign en       = !ctl_c[DIM_W].valid || take;
	assign s_tready = en;

	assign ctl_c[0] = '{valid: s_tvalid, diag: s_tuser, index: s_tdata};
	assign rem_c[0] = s_tdata;
	assign quo_c[0] = '0;

	for (genvar k = 0; k < DIM_W; k++) begin : g_cell
		gni_div_cell #(
			.DIM_W (DIM_W),
			.BIT   (DIM_W - 1 - k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.width  (width_q),
			.ctl_i  (ctl_c[k]),
			.rem_i  (rem_c[k]),
			.quo_i  (quo_c[k]),
			.ctl_o  (ctl_c[k+1]),
			.rem_o  (rem_c[k+1]),
			.quo_o  (quo_c[k+1])
		);
	end

	gni_emit #(
		.DIM_W (DIM_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.width     (width_q),
		.height    (height_q),
		.area      (area_q),
		.ctl_i     (ctl_c[DIM_W]),
		.rem_i     (rem_c[DIM_W]),
		.quo_i     (quo_c[DIM_W]),
		.take      (take),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (m_tdata),
		.out_found (m_tuser[0]),
		.out_error (m_tuser[1]),
		.out_last  (m_tlast)
	);

endmodule
